// ===== rtl/core/rfc_pkg.sv =====
// Shared types and constants of the report frame checker.
// Holds the status and report kind codes, frame layout constants and the queue entry type.
// No dependencies.
package rfc_pkg;

    // Field widths of the stream words.
    localparam int DATA_W      = 8;
    localparam int IDX_W       = 9;
    localparam int LEN_W       = 16;
    localparam int OUT_TDATA_W = 48;

    // Queue between the classifier and the output stage.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Frame layout.
    localparam logic [LEN_W-1:0]  HDR_BYTES   = 16'd7;
    localparam logic [LEN_W-1:0]  MIN_FRAME   = 16'd8;
    localparam logic [LEN_W-1:0]  POS_MAX     = 16'hFFFF;
    localparam logic [DATA_W-1:0] TYPE_MASK   = 8'hC0;
    localparam logic [DATA_W-1:0] TYPE_REPORT = 8'h80;
    localparam logic [DATA_W-1:0] FN_BOX      = 8'h72;
    localparam logic [DATA_W-1:0] FN_KEYPTS   = 8'h78;
    localparam logic [DATA_W-1:0] FN_TEXT     = 8'h73;

    // Final frame verdict.
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_TOO_SHORT    = 3'd1,
        ST_BAD_HEADER   = 3'd2,
        ST_TRUNCATED    = 3'd3,
        ST_BAD_CHECKSUM = 3'd4
    } t_status;

    // Report kind derived from control and function bytes.
    typedef enum logic [1:0] {
        KIND_BOX       = 2'd0,
        KIND_KEYPOINTS = 2'd1,
        KIND_TEXT      = 2'd2,
        KIND_IGNORED   = 2'd3
    } t_kind;

    // One queue entry: the results caused by one input word.
    typedef struct packed {
        logic              pay_valid;
        logic [DATA_W-1:0] pay_byte;
        logic [IDX_W-1:0]  pay_index;
        logic              stat_valid;
        t_status           code;
        t_kind             kind;
        logic [DATA_W-1:0] fn;
        logic [LEN_W-1:0]  len;
    } t_entry;

endpackage

// ===== rtl/core/rfc_front.sv =====
// Front part of the report frame checker: parses each accepted byte and builds queue entries.
// Tracks the byte position, length, checksum and header state of the current frame.
// Depends on rfc_pkg.
module rfc_front
    import rfc_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 512
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [DATA_W-1:0] i_byte,
    input  logic              i_end,
    input  logic [DATA_W-1:0] i_header_first,
    input  logic [DATA_W-1:0] i_header_second,
    output logic              o_push,
    output t_entry            o_entry
);

    // Header field positions within the frame.
    localparam logic [2:0] POS_LEN_HI = 3'd2;
    localparam logic [2:0] POS_LEN_LO = 3'd3;
    localparam logic [2:0] POS_CTRL   = 3'd4;
    localparam logic [2:0] POS_FUNC   = 3'd5;

    logic [LEN_W-1:0]  r_pos, n_pos;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [DATA_W-1:0] r_xor, n_xor;
    logic [DATA_W-1:0] r_ctrl, n_ctrl;
    logic [DATA_W-1:0] r_fn, n_fn;
    logic              r_hdr_bad, n_hdr_bad;
    logic              r_ck_bad, n_ck_bad;
    logic              r_ck_seen, n_ck_seen;

    logic [LEN_W:0]    csum_pos;
    logic [LEN_W:0]    pos_ext;
    logic [LEN_W:0]    frame_need;
    logic [LEN_W-1:0]  pay_idx;
    t_entry            entry;

    // Per-byte parsing and end-of-buffer verdict.
    always_comb begin
        n_pos      = r_pos;
        n_len      = r_len;
        n_xor      = r_xor;
        n_ctrl     = r_ctrl;
        n_fn       = r_fn;
        n_hdr_bad  = r_hdr_bad;
        n_ck_bad   = r_ck_bad;
        n_ck_seen  = r_ck_seen;
        entry      = '0;
        entry.code = ST_OK;
        entry.kind = KIND_BOX;
        csum_pos   = {1'b0, r_len} + {1'b0, HDR_BYTES};
        pos_ext    = {1'b0, r_pos};
        pay_idx    = r_pos - HDR_BYTES;
        frame_need = '0;

        if (i_accept) begin
            // A saturated counter ignores everything but the end mark.
            if (r_pos != POS_MAX) begin
                if (r_pos == '0) begin
                    if (i_byte != i_header_first) begin
                        n_hdr_bad = 1'b1;
                    end
                end else if (r_pos == 16'd1) begin
                    if (i_byte != i_header_second) begin
                        n_hdr_bad = 1'b1;
                    end
                end else if (r_pos < HDR_BYTES) begin
                    n_xor = r_xor ^ i_byte;
                    case (r_pos[2:0])
                        POS_LEN_HI: n_len  = {i_byte, r_len[7:0]};
                        POS_LEN_LO: n_len  = {r_len[15:8], i_byte};
                        POS_CTRL:   n_ctrl = i_byte;
                        POS_FUNC:   n_fn   = i_byte;
                        default: ;
                    endcase
                end else if (pos_ext < csum_pos) begin
                    // Payload byte: always enters the checksum, emitted while in range.
                    n_xor = r_xor ^ i_byte;
                    if ({1'b0, pay_idx} < (LEN_W+1)'(MAX_PAYLOAD_BYTES)) begin
                        entry.pay_valid = 1'b1;
                        entry.pay_byte  = i_byte;
                        entry.pay_index = pay_idx[IDX_W-1:0];
                    end
                end else if (pos_ext == csum_pos && !r_ck_seen) begin
                    n_ck_seen = 1'b1;
                    n_ck_bad  = (i_byte != r_xor);
                end
                n_pos = r_pos + 16'd1;
            end

            if (i_end) begin
                frame_need = {1'b0, n_len} + {1'b0, MIN_FRAME};
                if (n_pos < MIN_FRAME) begin
                    entry.code = ST_TOO_SHORT;
                end else if (n_hdr_bad) begin
                    entry.code = ST_BAD_HEADER;
                end else if ({1'b0, n_pos} < frame_need || !n_ck_seen) begin
                    entry.code = ST_TRUNCATED;
                end else if (n_ck_bad) begin
                    entry.code = ST_BAD_CHECKSUM;
                end else begin
                    entry.code = ST_OK;
                end

                entry.kind = KIND_IGNORED;
                if (entry.code == ST_OK && (n_ctrl & TYPE_MASK) == TYPE_REPORT) begin
                    if (n_fn == FN_BOX) begin
                        entry.kind = KIND_BOX;
                    end else if (n_fn == FN_KEYPTS) begin
                        entry.kind = KIND_KEYPOINTS;
                    end else if (n_fn == FN_TEXT) begin
                        entry.kind = KIND_TEXT;
                    end
                end
                entry.stat_valid = 1'b1;
                entry.fn         = n_fn;
                entry.len        = n_len;

                // Start over for the next buffer.
                n_pos     = '0;
                n_len     = '0;
                n_xor     = '0;
                n_ctrl    = '0;
                n_fn      = '0;
                n_hdr_bad = 1'b0;
                n_ck_bad  = 1'b0;
                n_ck_seen = 1'b0;
            end
        end
    end

    assign o_push  = entry.pay_valid | entry.stat_valid;
    assign o_entry = entry;

    // Frame state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_len     <= '0;
            r_xor     <= '0;
            r_ctrl    <= '0;
            r_fn      <= '0;
            r_hdr_bad <= 1'b0;
            r_ck_bad  <= 1'b0;
            r_ck_seen <= 1'b0;
        end else begin
            r_pos     <= n_pos;
            r_len     <= n_len;
            r_xor     <= n_xor;
            r_ctrl    <= n_ctrl;
            r_fn      <= n_fn;
            r_hdr_bad <= n_hdr_bad;
            r_ck_bad  <= n_ck_bad;
            r_ck_seen <= n_ck_seen;
        end
    end

endmodule

// ===== rtl/core/rfc_queue.sv =====
// Short queue of result entries between the front and back parts.
// One entry per input word that causes results; head entry is shown combinationally.
// Depends on rfc_pkg.
module rfc_queue
    import rfc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_empty,
    output t_entry o_head
);

    t_entry             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  r_wr_ptr;
    logic [QPTR_W-1:0]  r_rd_ptr;
    logic [QCNT_W-1:0]  r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/rfc_back.sv =====
// Back part of the report frame checker: turns queue entries into output words.
// An entry with a payload byte and a status gives two words, payload first.
// Depends on rfc_pkg.
module rfc_back
    import rfc_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_entry                 i_head,
    input  logic                   i_empty,
    output logic                   o_pop,
    input  logic                   i_tready,
    output logic                   o_tvalid,
    output logic [OUT_TDATA_W-1:0] o_tdata,
    output logic                   o_tuser,
    output logic                   o_tlast
);

    logic                   r_valid, n_valid;
    logic [OUT_TDATA_W-1:0] r_data, n_data;
    logic                   r_user, n_user;
    logic                   r_last, n_last;
    logic                   r_phase, n_phase;
    logic                   load;

    assign load = !r_valid || i_tready;

    // Output register load and queue pop.
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        n_user  = r_user;
        n_last  = r_last;
        n_phase = r_phase;
        o_pop   = 1'b0;
        if (load) begin
            if (!i_empty) begin
                n_valid = 1'b1;
                if (i_head.pay_valid && !r_phase) begin
                    n_data = OUT_TDATA_W'({i_head.pay_index, i_head.pay_byte});
                    n_user = 1'b0;
                    n_last = 1'b0;
                    if (i_head.stat_valid) begin
                        n_phase = 1'b1;
                    end else begin
                        o_pop = 1'b1;
                    end
                end else begin
                    n_data  = OUT_TDATA_W'({i_head.len, i_head.fn, i_head.kind,
                                            i_head.code, {(IDX_W+DATA_W){1'b0}}});
                    n_user  = 1'b1;
                    n_last  = 1'b1;
                    n_phase = 1'b0;
                    o_pop   = 1'b1;
                end
            end else begin
                n_valid = 1'b0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_phase <= n_phase;
        end
    end

    // Output word registers.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
        r_user <= n_user;
        r_last <= n_last;
    end

    assign o_tvalid = r_valid;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;
    assign o_tlast  = r_last;

endmodule

// ===== rtl/core/report_frame_checker.sv =====
// Report frame checker: bytes in, payload words and one status word per frame out.
// A result word is held in a queue entry, then in the output register, before it leaves.
// Input takes one byte per cycle while the queue has room; a byte that ends the buffer inside the
// payload gives two output words in turn from the output register, and the queue absorbs it.
// Reset (synchronous, active low) clears frame state, queue and output; headers go to AA/55.
module report_frame_checker
    import rfc_pkg::*;
#(
    parameter int MAX_PAYLOAD_BYTES = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Input stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [7:0] data_byte
    input  logic                   s_axis_tlast,
    // Output stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [7:0] payload_byte, [16:8] payload_index, [19:17] status_code,
    // [21:20] report_kind, [29:22] function_code, [45:30] payload_length, [47:46] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                   m_axis_tuser,   // [0] is_status
    output logic                   m_axis_tlast,
    // Register port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    localparam logic REG_HEADER_FIRST  = 1'b0;
    localparam logic REG_HEADER_SECOND = 1'b1;

    logic [DATA_W-1:0] r_header_first;
    logic [DATA_W-1:0] r_header_second;
    logic              cfg_write;
    logic              in_accept;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    t_entry            entry;
    t_entry            head;

    // Register port: always ready, register chosen by address bit 2.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_HEADER_SECOND) ? 32'(r_header_second)
                                                       : 32'(r_header_first);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= 8'hAA;
            r_header_second <= 8'h55;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_HEADER_FIRST:  r_header_first  <= pwdata[DATA_W-1:0];
                REG_HEADER_SECOND: r_header_second <= pwdata[DATA_W-1:0];
                default: ;
            endcase
        end
    end

    // Input side takes a word whenever the queue has room.
    assign s_axis_tready = !q_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    rfc_front #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_accept),
        .i_byte          (s_axis_tdata),
        .i_end           (s_axis_tlast),
        .i_header_first  (r_header_first),
        .i_header_second (r_header_second),
        .o_push          (push),
        .o_entry         (entry)
    );

    rfc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    rfc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .i_tready (m_axis_tready),
        .o_tvalid (m_axis_tvalid),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser),
        .o_tlast  (m_axis_tlast)
    );

    // A status word is always the last word of its frame, a payload word never is.
    a_status_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == m_axis_tlast))
        else $error("status flag and last flag disagree");

    // Status words carry a defined verdict code.
    a_status_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[19:17] <= ST_BAD_CHECKSUM))
        else $error("status code out of range");

    // Payload words leave all status fields at zero.
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[OUT_TDATA_W-1:17] == '0))
        else $error("payload word carries status fields");

    // The output is empty right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule
